FILE: rtl/ntw_pkg.sv
// Shared types, word codes and the sequencer microprogram for number_to_word_tokens.
package ntw_pkg;

   localparam int NumW      = 40;
   localparam int WordW     = 5;
   localparam int Digits    = 13;
   localparam int BcdW      = 4 * Digits;
   localparam int ConvSteps = NumW;
   localparam int ConvCntW  = $clog2(ConvSteps);
   localparam int MaxWords  = 16;
   localparam int CntW      = $clog2(MaxWords + 1);
   localparam int StepW     = 5;

   localparam logic [WordW-1:0] W_ZERO     = 5'd0;
   localparam logic [WordW-1:0] W_TEN      = 5'd10;
   localparam logic [WordW-1:0] W_TWENTY   = 5'd20;
   localparam logic [WordW-1:0] W_TENS_OFS = 5'd18;
   localparam logic [WordW-1:0] W_HUNDRED  = 5'd28;
   localparam logic [WordW-1:0] W_THOUSAND = 5'd29;
   localparam logic [WordW-1:0] W_MILLION  = 5'd30;
   localparam logic [WordW-1:0] W_BILLION  = 5'd31;

   // three-digit groups, units group lowest; GRP_TB is the lone top digit
   localparam logic [2:0] GRP_U  = 3'd0;
   localparam logic [2:0] GRP_T  = 3'd1;
   localparam logic [2:0] GRP_M  = 3'd2;
   localparam logic [2:0] GRP_B  = 3'd3;
   localparam logic [2:0] GRP_TB = 3'd4;

   localparam logic [StepW-1:0] STEP_END = 5'd25;

   typedef enum logic [2:0] {
      OP_ZERO  = 3'd0,
      OP_SKIPZ = 3'd1,
      OP_HDIG  = 3'd2,
      OP_HUND  = 3'd3,
      OP_TENS  = 3'd4,
      OP_UNITS = 3'd5,
      OP_SCALE = 3'd6,
      OP_END   = 3'd7
   } op_type;

   typedef struct packed {
      op_type           op;
      logic [2:0]       grp;
      logic [WordW-1:0] word;
      logic [StepW-1:0] target;
   } uc_type;

   function automatic uc_type uc_word(input op_type op, input logic [2:0] grp,
                                      input logic [WordW-1:0] word,
                                      input logic [StepW-1:0] target);
      uc_type u;
      u.op     = op;
      u.grp    = grp;
      u.word   = word;
      u.target = target;
      return u;
   endfunction

   function automatic uc_type ucode_rom(input logic [StepW-1:0] step);
      uc_type u;
      unique case (step)
         5'd0:    u = uc_word(OP_ZERO,  GRP_U,  W_ZERO,     5'd0);
         5'd1:    u = uc_word(OP_SKIPZ, GRP_B,  W_ZERO,     5'd9);
         5'd2:    u = uc_word(OP_TENS,  GRP_TB, W_ZERO,     5'd0);
         5'd3:    u = uc_word(OP_SCALE, GRP_TB, W_THOUSAND, 5'd0);
         5'd4:    u = uc_word(OP_HDIG,  GRP_B,  W_ZERO,     5'd0);
         5'd5:    u = uc_word(OP_HUND,  GRP_B,  W_ZERO,     5'd0);
         5'd6:    u = uc_word(OP_TENS,  GRP_B,  W_ZERO,     5'd0);
         5'd7:    u = uc_word(OP_UNITS, GRP_B,  W_ZERO,     5'd0);
         5'd8:    u = uc_word(OP_SCALE, GRP_B,  W_BILLION,  5'd0);
         5'd9:    u = uc_word(OP_SKIPZ, GRP_M,  W_ZERO,     5'd15);
         5'd10:   u = uc_word(OP_HDIG,  GRP_M,  W_ZERO,     5'd0);
         5'd11:   u = uc_word(OP_HUND,  GRP_M,  W_ZERO,     5'd0);
         5'd12:   u = uc_word(OP_TENS,  GRP_M,  W_ZERO,     5'd0);
         5'd13:   u = uc_word(OP_UNITS, GRP_M,  W_ZERO,     5'd0);
         5'd14:   u = uc_word(OP_SCALE, GRP_M,  W_MILLION,  5'd0);
         5'd15:   u = uc_word(OP_SKIPZ, GRP_T,  W_ZERO,     5'd21);
         5'd16:   u = uc_word(OP_HDIG,  GRP_T,  W_ZERO,     5'd0);
         5'd17:   u = uc_word(OP_HUND,  GRP_T,  W_ZERO,     5'd0);
         5'd18:   u = uc_word(OP_TENS,  GRP_T,  W_ZERO,     5'd0);
         5'd19:   u = uc_word(OP_UNITS, GRP_T,  W_ZERO,     5'd0);
         5'd20:   u = uc_word(OP_SCALE, GRP_T,  W_THOUSAND, 5'd0);
         5'd21:   u = uc_word(OP_HDIG,  GRP_U,  W_ZERO,     5'd0);
         5'd22:   u = uc_word(OP_HUND,  GRP_U,  W_ZERO,     5'd0);
         5'd23:   u = uc_word(OP_TENS,  GRP_U,  W_ZERO,     5'd0);
         5'd24:   u = uc_word(OP_UNITS, GRP_U,  W_ZERO,     5'd0);
         default: u = uc_word(OP_END,   GRP_U,  W_ZERO,     5'd0);
      endcase
      return u;
   endfunction

endpackage

FILE: rtl/ntw_if.sv
// Valid/ready channel interfaces for the number input and the word output.
interface ntw_req_if;
   logic                     valid;
   logic                     ready;
   logic [ntw_pkg::NumW-1:0] number;

   modport source (output valid, output number, input ready);
   modport sink   (input valid, input number, output ready);
endinterface

interface ntw_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [ntw_pkg::WordW-1:0] word;
   logic                      last;

   modport source (output valid, output word, output last, input ready);
   modport sink   (input valid, input word, input last, output ready);
endinterface

FILE: rtl/number_to_word_tokens.sv
// Number to word tokens: binary-to-BCD converter and microcoded word sequencer.
// Flow: take the number, run the 40-step shift-and-adjust converter, then 9 to 26 microcode steps.
// Words go out through a pending word and the output register, and the sequencer waits on output stalls.
// A new number is taken only in idle, once the last word has been pushed into the output register.
// Synchronous active-high reset returns the sequencer to idle and empties the output register.
module number_to_word_tokens (
   input logic clock,
   input logic reset,
   ntw_req_if.sink   req_ch,
   ntw_rsp_if.source rsp_ch
);
   import ntw_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_CONV = 3'b010,
      ST_RUN  = 3'b100
   } state_type;

   state_type            state_ff, state_in;
   logic [NumW-1:0]      bin_ff, bin_in;
   logic [BcdW-1:0]      bcd_ff, bcd_in;
   logic [BcdW-1:0]      bcd_adj;
   logic [ConvCntW-1:0]  conv_cnt_ff, conv_cnt_in;
   logic [StepW-1:0]     step_ff, step_in;
   logic [CntW-1:0]      cnt_ff, cnt_in;
   logic                 pend_valid_ff, pend_valid_in;
   logic [WordW-1:0]     pend_word_ff, pend_word_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [WordW-1:0]     rsp_word_ff, rsp_word_in;
   logic                 rsp_last_ff, rsp_last_in;

   uc_type               uc;
   logic [11:0]          grp_dig;
   logic [3:0]           dig_h, dig_t, dig_u;
   logic                 grp_nz;
   logic                 all_zero;
   logic                 emit_en;
   logic [WordW-1:0]     emit_code;
   logic                 slot_free;
   logic                 push, push_last;

   assign uc        = ucode_rom(step_ff);
   assign slot_free = !rsp_valid_ff || rsp_ch.ready;
   assign all_zero  = (bcd_ff == '0);

   always_comb begin
      unique case (uc.grp)
         GRP_U:   grp_dig = bcd_ff[11:0];
         GRP_T:   grp_dig = bcd_ff[23:12];
         GRP_M:   grp_dig = bcd_ff[35:24];
         GRP_B:   grp_dig = bcd_ff[47:36];
         GRP_TB:  grp_dig = {8'd0, bcd_ff[51:48]};
         default: grp_dig = '0;
      endcase
   end

   assign dig_h = grp_dig[11:8];
   assign dig_t = grp_dig[7:4];
   assign dig_u = grp_dig[3:0];
   // the billions count also covers the lone top digit
   assign grp_nz = (grp_dig != '0) || ((uc.grp == GRP_B) && (bcd_ff[51:48] != '0));

   always_comb begin
      emit_en   = 1'b0;
      emit_code = W_ZERO;
      unique case (uc.op)
         OP_ZERO: begin
            emit_en   = all_zero;
            emit_code = W_ZERO;
         end
         OP_HDIG: begin
            emit_en   = (dig_h != '0);
            emit_code = WordW'(dig_h);
         end
         OP_HUND: begin
            emit_en   = (dig_h != '0);
            emit_code = W_HUNDRED;
         end
         OP_TENS: begin
            if (dig_t >= 4'd2) begin
               emit_en   = 1'b1;
               emit_code = (dig_t == 4'd2) ? W_TWENTY : WordW'(dig_t) + W_TENS_OFS;
            end else begin
               emit_en   = (dig_t != '0) || (dig_u != '0);
               emit_code = dig_t[0] ? WordW'(dig_u) + W_TEN : WordW'(dig_u);
            end
         end
         OP_UNITS: begin
            emit_en   = (dig_t >= 4'd2) && (dig_u != '0);
            emit_code = WordW'(dig_u);
         end
         OP_SCALE: begin
            emit_en   = grp_nz;
            emit_code = uc.word;
         end
         default: begin
            emit_en   = 1'b0;
            emit_code = W_ZERO;
         end
      endcase
   end

   always_comb begin
      for (int i = 0; i < Digits; i++) begin
         bcd_adj[4*i +: 4] = (bcd_ff[4*i +: 4] >= 4'd5) ? bcd_ff[4*i +: 4] + 4'd3
                                                        : bcd_ff[4*i +: 4];
      end
   end

   always_comb begin
      state_in      = state_ff;
      bin_in        = bin_ff;
      bcd_in        = bcd_ff;
      conv_cnt_in   = conv_cnt_ff;
      step_in       = step_ff;
      cnt_in        = cnt_ff;
      pend_valid_in = pend_valid_ff;
      pend_word_in  = pend_word_ff;
      push          = 1'b0;
      push_last     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               bin_in      = req_ch.number;
               bcd_in      = '0;
               conv_cnt_in = '0;
               state_in    = ST_CONV;
            end
         end
         ST_CONV: begin
            bcd_in      = {bcd_adj[BcdW-2:0], bin_ff[NumW-1]};
            bin_in      = {bin_ff[NumW-2:0], 1'b0};
            conv_cnt_in = conv_cnt_ff + 1'b1;
            if (conv_cnt_ff == ConvCntW'(ConvSteps - 1)) begin
               state_in      = ST_RUN;
               step_in       = '0;
               cnt_in        = '0;
               pend_valid_in = 1'b0;
            end
         end
         ST_RUN: begin
            if (uc.op == OP_END) begin
               if (slot_free) begin
                  push          = 1'b1;
                  push_last     = 1'b1;
                  pend_valid_in = 1'b0;
                  state_in      = ST_IDLE;
               end
            end else if (uc.op == OP_SKIPZ) begin
               step_in = grp_nz ? step_ff + 1'b1 : uc.target;
            end else if (emit_en) begin
               if (!pend_valid_ff || slot_free) begin
                  push          = pend_valid_ff;
                  pend_word_in  = emit_code;
                  pend_valid_in = 1'b1;
                  cnt_in        = cnt_ff + 1'b1;
                  step_in       = (cnt_ff == CntW'(MaxWords - 1)) ? STEP_END
                                                                 : step_ff + 1'b1;
               end
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_word_in  = rsp_word_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      if (push) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = pend_word_ff;
         rsp_last_in  = push_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         step_ff       <= '0;
         cnt_ff        <= '0;
         conv_cnt_ff   <= '0;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         step_ff       <= step_in;
         cnt_ff        <= cnt_in;
         conv_cnt_ff   <= conv_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff       <= bin_in;
      bcd_ff       <= bcd_in;
      pend_word_ff <= pend_word_in;
      rsp_word_ff  <= rsp_word_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.word  = rsp_word_ff;
   assign rsp_ch.last  = rsp_last_ff;

   a_accept_starts_conv: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> (state_ff == ST_CONV))
      else $error("transfer in did not start conversion");

   a_word_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CntW'(MaxWords))
      else $error("word count beyond limit");

   a_no_pending_in_conv: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CONV) |-> !pend_valid_ff)
      else $error("pending word held during conversion");

   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      (push && push_last) |=> (state_ff == ST_IDLE && rsp_valid_ff && rsp_last_ff))
      else $error("final word did not close the run");

   a_push_needs_slot: assert property (@(posedge clock) disable iff (reset)
      push |-> slot_free)
      else $error("output register overwritten");

endmodule
